FILE: design/srctok_pkg.sv
package srctok_pkg;

	// Width of the byte offset counter; offsets wrap at 2**OFFSET_BITS
	localparam int OFFSET_BITS = 16;

	// Token groups buffered between the classifier and the serializer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	// Most tokens that one source byte can produce
	localparam int GROUP_SLOTS = 3;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	// Token kinds as they appear in token_kind
	typedef enum logic [3:0] {
		TK_UNKNOWN = 4'd0,
		TK_OPEN    = 4'd1,
		TK_CLOSE   = 4'd2,
		TK_EQUALS  = 4'd3,
		TK_LESS    = 4'd4,
		TK_PLUS    = 4'd5,
		TK_DIVIDE  = 4'd6,
		TK_INC     = 4'd7,
		TK_KEYWORD = 4'd8,
		TK_IDENT   = 4'd9,
		TK_NUMBER  = 4'd10,
		TK_END     = 4'd11
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       final_byte;
	} src_item_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [1:0]  keyword_index;
		logic        run_last;
	} tok_item_t;

	// One token without its position in the group
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  kw;
	} token_t;

	// Tokens produced by one source byte, in output order
	typedef struct packed {
		logic [1:0]                  count;
		token_t [GROUP_SLOTS-1:0]    tok;
	} group_t;

	// Head of the queue as seen by the serializer
	typedef struct packed {
		logic   empty;
		group_t head;
	} queue_view_t;

	// Reduce an offset to the 16-bit start field
	function automatic logic [15:0] start_field(input offset_t pos);
		logic [31:0] wide;
		wide = 32'(pos);
		return wide[15:0];
	endfunction

endpackage

FILE: design/srctok_front.sv
module srctok_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  srctok_pkg::src_item_t  src_item,
	input  logic                   queue_full,
	output logic                   push,
	output srctok_pkg::group_t     push_group
);

	typedef enum logic [2:0] {
		PK_NONE    = 3'd0,
		PK_IDENT   = 3'd1,
		PK_NUMBER  = 3'd2,
		PK_SLASH   = 3'd3,
		PK_PLUS    = 3'd4,
		PK_COMMENT = 3'd5
	} pend_kind_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LESS  = 8'h3C;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [2:0]  ALL_CAND = 3'b111;
	localparam logic [15:0] LEN_MAX  = 16'hFFFF;

	localparam int NUM_CAND = 4;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
	endfunction

	// Keyword spelling: 0 "if", 1 "while", 2 "int"
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			2'd0: begin
				case (idx)
					3'd0: c = 8'h69;
					3'd1: c = 8'h66;
					default: c = 8'h00;
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0: c = 8'h77;
					3'd1: c = 8'h68;
					3'd2: c = 8'h69;
					3'd3: c = 8'h6C;
					3'd4: c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			2'd2: begin
				case (idx)
					3'd0: c = 8'h69;
					3'd1: c = 8'h6E;
					3'd2: c = 8'h74;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] kw_len(input logic [1:0] k);
		logic [15:0] n;
		unique case (k)
			2'd0: n = 16'd2;
			2'd1: n = 16'd5;
			2'd2: n = 16'd3;
			default: n = 16'd0;
		endcase
		return n;
	endfunction

	// Keep the keywords whose character at idx equals b
	function automatic logic [2:0] filter_cand(input logic [2:0] cand, input logic [15:0] idx,
			input logic [7:0] b);
		logic [2:0] r;
		r = 3'b000;
		for (int i = 0; i < 3; i++) begin
			if (cand[i] && (idx < kw_len(2'(i))) && (kw_char(2'(i), idx[2:0]) == b)) begin
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic srctok_pkg::token_t make_tok(input srctok_pkg::tok_kind_t kind,
			input srctok_pkg::offset_t pos, input logic [15:0] len, input logic [1:0] kw);
		srctok_pkg::token_t t;
		t.kind   = kind;
		t.start  = srctok_pkg::start_field(pos);
		t.length = len;
		t.kw     = kw;
		return t;
	endfunction

	function automatic logic pend_has_tok(input pend_kind_t kind);
		return (kind == PK_IDENT) || (kind == PK_NUMBER) || (kind == PK_SLASH)
			|| (kind == PK_PLUS);
	endfunction

	// Token that a pending run turns into when it is closed
	function automatic srctok_pkg::token_t pend_tok(input pend_kind_t kind,
			input srctok_pkg::offset_t pos, input logic [15:0] len, input logic [2:0] cand);
		srctok_pkg::token_t     t;
		srctok_pkg::tok_kind_t  k;
		logic [1:0]             kw;
		k  = srctok_pkg::TK_IDENT;
		kw = 2'd0;
		case (kind)
			PK_IDENT: begin
				for (int i = 2; i >= 0; i--) begin
					if (cand[i] && (len == kw_len(2'(i)))) begin
						k  = srctok_pkg::TK_KEYWORD;
						kw = 2'(i);
					end
				end
				t = make_tok(k, pos, len, kw);
			end
			PK_NUMBER: t = make_tok(srctok_pkg::TK_NUMBER, pos, len, 2'd0);
			PK_SLASH:  t = make_tok(srctok_pkg::TK_DIVIDE, pos, 16'd1, 2'd0);
			default:   t = make_tok(srctok_pkg::TK_PLUS, pos, 16'd1, 2'd0);
		endcase
		return t;
	endfunction

	pend_kind_t          pkind_q;
	srctok_pkg::offset_t pos_q;
	srctok_pkg::offset_t pstart_q;
	logic [15:0]         plen_q;
	logic [2:0]          cand_q;

	pend_kind_t          nkind;
	srctok_pkg::offset_t nstart;
	logic [15:0]         nlen;
	logic [2:0]          ncand;
	logic                consumed;
	logic [15:0]         plen_inc;
	logic [7:0]          b;
	logic                accept;

	logic                   cand_v [NUM_CAND];
	srctok_pkg::token_t     cand_t [NUM_CAND];
	logic [2:0]             n_tok;
	srctok_pkg::group_t     grp;

	assign b         = src_item.source_byte;
	assign src_ready = !queue_full;
	assign accept    = src_valid && src_ready;
	assign plen_inc  = (plen_q == LEN_MAX) ? plen_q : (plen_q + 16'd1);

	// Classify the byte against the pending run and build its tokens
	always_comb begin
		nkind    = pkind_q;
		nstart   = pstart_q;
		nlen     = plen_q;
		ncand    = cand_q;
		consumed = 1'b0;
		for (int i = 0; i < NUM_CAND; i++) begin
			cand_v[i] = 1'b0;
			cand_t[i] = '0;
		end

		// Continue or close the pending run
		case (pkind_q) inside
			PK_COMMENT: begin
				consumed = 1'b1;
				if (b == CH_LF) begin
					nkind = PK_NONE;
					nlen  = 16'd0;
				end
			end
			PK_SLASH, PK_PLUS, PK_IDENT, PK_NUMBER: begin
				if ((pkind_q == PK_SLASH) && (b == CH_SLASH)) begin
					nkind    = PK_COMMENT;
					consumed = 1'b1;
				end else if ((pkind_q == PK_PLUS) && (b == CH_PLUS)) begin
					cand_v[0] = 1'b1;
					cand_t[0] = make_tok(srctok_pkg::TK_INC, pstart_q, 16'd2, 2'd0);
					nkind     = PK_NONE;
					nlen      = 16'd0;
					consumed  = 1'b1;
				end else if ((pkind_q == PK_IDENT) && is_word(b)) begin
					ncand    = filter_cand(cand_q, plen_q, b);
					nlen     = plen_inc;
					consumed = 1'b1;
				end else if ((pkind_q == PK_NUMBER) && is_digit(b)) begin
					nlen     = plen_inc;
					consumed = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					cand_t[0] = pend_tok(pkind_q, pstart_q, plen_q, cand_q);
					nkind     = PK_NONE;
					nlen      = 16'd0;
					ncand     = ALL_CAND;
				end
			end
			default: nkind = PK_NONE;
		endcase

		// Start a new token from a byte that nothing took
		if (!consumed) begin
			case (b) inside
				CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_QUOTE: ;
				CH_SLASH, CH_PLUS: begin
					nkind  = (b == CH_SLASH) ? PK_SLASH : PK_PLUS;
					nstart = pos_q;
					nlen   = 16'd1;
				end
				CH_OPEN: begin
					cand_v[1] = 1'b1;
					cand_t[1] = make_tok(srctok_pkg::TK_OPEN, pos_q, 16'd1, 2'd0);
				end
				CH_CLOSE: begin
					cand_v[1] = 1'b1;
					cand_t[1] = make_tok(srctok_pkg::TK_CLOSE, pos_q, 16'd1, 2'd0);
				end
				CH_EQ: begin
					cand_v[1] = 1'b1;
					cand_t[1] = make_tok(srctok_pkg::TK_EQUALS, pos_q, 16'd1, 2'd0);
				end
				CH_LESS: begin
					cand_v[1] = 1'b1;
					cand_t[1] = make_tok(srctok_pkg::TK_LESS, pos_q, 16'd1, 2'd0);
				end
				default: begin
					if (is_alpha(b) || (b == CH_UNDER)) begin
						nkind  = PK_IDENT;
						nstart = pos_q;
						nlen   = 16'd1;
						ncand  = filter_cand(ALL_CAND, 16'd0, b);
					end else if (is_digit(b)) begin
						nkind  = PK_NUMBER;
						nstart = pos_q;
						nlen   = 16'd1;
					end else begin
						cand_v[1] = 1'b1;
						cand_t[1] = make_tok(srctok_pkg::TK_UNKNOWN, pos_q, 16'd1, 2'd0);
					end
				end
			endcase
		end

		// Flush what is left at the last byte and close with an end token
		if (src_item.final_byte) begin
			cand_v[2] = pend_has_tok(nkind);
			cand_t[2] = pend_tok(nkind, nstart, nlen, ncand);
			cand_v[3] = 1'b1;
			cand_t[3] = make_tok(srctok_pkg::TK_END, pos_q + 1'b1, 16'd0, 2'd0);
		end
	end

	// Pack the tokens of this byte into consecutive slots
	always_comb begin
		grp   = '0;
		n_tok = 3'd0;
		for (int i = 0; i < NUM_CAND; i++) begin
			if (cand_v[i]) begin
				if (n_tok < 3'(srctok_pkg::GROUP_SLOTS)) begin
					grp.tok[n_tok[1:0]] = cand_t[i];
				end
				n_tok = n_tok + 3'd1;
			end
		end
		grp.count = n_tok[1:0];
	end

	assign push       = accept && (n_tok != 3'd0);
	assign push_group = grp;

	// Advance the lexer state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkind_q  <= PK_NONE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			cand_q   <= ALL_CAND;
		end else if (accept) begin
			if (src_item.final_byte) begin
				pkind_q  <= PK_NONE;
				pos_q    <= '0;
				pstart_q <= '0;
				plen_q   <= '0;
				cand_q   <= ALL_CAND;
			end else begin
				pkind_q  <= nkind;
				pos_q    <= pos_q + 1'b1;
				pstart_q <= nstart;
				plen_q   <= nlen;
				cand_q   <= ncand;
			end
		end
	end

endmodule

FILE: design/srctok_fifo.sv
module srctok_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  srctok_pkg::group_t       push_group,
	input  logic                     pop,
	output srctok_pkg::queue_view_t  view,
	output logic                     full
);

	localparam int PB = srctok_pkg::QUEUE_PTR_BITS;

	srctok_pkg::group_t entries_q [srctok_pkg::QUEUE_DEPTH];
	logic [PB-1:0]      wr_ptr_q;
	logic [PB-1:0]      rd_ptr_q;
	logic [PB:0]        count_q;
	logic               do_pop;

	assign full       = (count_q == (PB+1)'(srctok_pkg::QUEUE_DEPTH));
	assign view.empty = (count_q == '0);
	assign view.head  = entries_q[rd_ptr_q];
	assign do_pop     = pop && !view.empty;

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_group;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/srctok_back.sv
module srctok_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  srctok_pkg::queue_view_t  view,
	output logic                     pop,
	output logic                     tok_valid,
	input  logic                     tok_ready,
	output srctok_pkg::tok_item_t    tok_item
);

	logic [1:0]         idx_q;
	logic               last;
	srctok_pkg::token_t cur;

	assign cur       = view.head.tok[idx_q];
	assign last      = (idx_q == 2'(view.head.count - 2'd1));
	assign tok_valid = !view.empty;
	assign pop       = tok_valid && tok_ready && last;

	always_comb begin
		tok_item.token_kind    = cur.kind;
		tok_item.token_start   = cur.start;
		tok_item.token_length  = cur.length;
		tok_item.keyword_index = cur.kw;
		tok_item.run_last      = last;
	end

	// Step through the head group, one token per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (tok_valid && tok_ready) begin
			if (last) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

FILE: design/source_tokenizer_core.sv
// Streaming source lexer: accepts one source byte per cycle on src and returns tokens on tok
// (kind, start offset, saturating length, keyword index, run_last on the last token of a
// byte). A byte is accepted whenever the four-entry token-group queue between the classifier
// and the serializer has room; the classifier handles every byte as it is accepted and pushes
// the one to three tokens it produces as one group, if any. Tokens leave at one per cycle while
// tok_ready is high, so the output port sets the sustained rate; the first token of a
// byte is offered once its group reaches the head of the registered queue. A byte with
// final_byte set flushes any pending token, appends the end token and restarts offsets at 0.
module source_tokenizer_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  srctok_pkg::src_item_t  src_item,
	output logic                   tok_valid,
	input  logic                   tok_ready,
	output srctok_pkg::tok_item_t  tok_item
);

	logic                     push;
	srctok_pkg::group_t       push_group;
	logic                     pop;
	logic                     queue_full;
	srctok_pkg::queue_view_t  view;

	srctok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_item   (src_item),
		.queue_full (queue_full),
		.push       (push),
		.push_group (push_group)
	);

	srctok_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.view       (view),
		.full       (queue_full)
	);

	srctok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.view      (view),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

FILE: design/srctok_checker.sv
module srctok_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   tok_valid,
	input logic                   tok_ready,
	input srctok_pkg::tok_item_t  tok_item
);

	// Hold a stalled token offer
	a_tok_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("token offer dropped before accept");

	a_tok_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> $stable(tok_item))
		else $error("stalled token changed");

	// End token closes its byte's run and has no length
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_kind == srctok_pkg::TK_END)
		|-> tok_item.run_last && (tok_item.token_length == 16'd0))
		else $error("end token malformed");

	// Every other token covers at least one character
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_kind != srctok_pkg::TK_END)
		|-> (tok_item.token_length != 16'd0))
		else $error("empty token");

	// Keyword index only on keywords
	a_kw_index: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_kind != srctok_pkg::TK_KEYWORD)
		|-> (tok_item.keyword_index == 2'd0))
		else $error("keyword index on non-keyword");

endmodule

bind source_tokenizer_core srctok_checker u_srctok_checker (.*);
